// ===== design/prsc_pkg.sv =====
// Package for the pinned-prefix round-robin slot cache.
// Holds field widths, status codes, register indexes, reset values and parameter defaults.
// No dependencies.
package prsc_pkg;

   // Parameter defaults
   localparam int MAX_LAYERS_DEF = 64;
   localparam int MAX_SLOTS_DEF  = 16;

   // Field widths
   localparam int LAYER_W      = 6;
   localparam int STATUS_W     = 3;
   localparam int SLOT_W       = 4;
   localparam int CNT_W        = 32;
   localparam int LAYER_CNT_W  = 7;
   localparam int SLOT_CNT_W   = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   // Result status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_PINNED_HIT  = 3'd0;
   localparam status_type ST_PINNED_LOAD = 3'd1;
   localparam status_type ST_RING_HIT    = 3'd2;
   localparam status_type ST_RING_LOAD   = 3'd3;
   localparam status_type ST_ABSENT      = 3'd4;

   // Configuration register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_LAYER_COUNT  = 2'd0;
   localparam csr_index_type CSR_PINNED_COUNT = 2'd1;
   localparam csr_index_type CSR_SLOT_COUNT   = 2'd2;
   localparam csr_index_type CSR_PRESENT_MASK = 2'd3;

   // Configuration reset values
   localparam logic [LAYER_CNT_W-1:0] LAYER_COUNT_RST  = 7'd64;
   localparam logic [LAYER_CNT_W-1:0] PINNED_COUNT_RST = 7'd0;
   localparam logic [SLOT_CNT_W-1:0]  SLOT_COUNT_RST   = 5'd1;
   localparam logic [CSR_DATA_W-1:0]  PRESENT_MASK_RST = {CSR_DATA_W{1'b1}};

   localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

endpackage

// ===== design/pinned_prefix_round_robin_slot_cache.sv =====
// Pinned-prefix round-robin slot cache: decides where a requested layer's
// weights live and reports hits, loads and evictions.
// Depends on prsc_pkg.
//
//   Channel   Ports                               Beat taken when
//   -------   ---------------------------------   ----------------------------
//   request   start, busy, req_layer              start high, busy low
//   result    rsp_valid, rsp_status ... totals    rsp_valid high (one cycle)
//   config    csr_wr_en, csr_index, csr_wr_data   csr_wr_en high
//
// A request beat is registered, looked up and resolved in the following cycle.
// Its result is then held in the result register, where the receiver takes it.
// A new request may be given every cycle; busy stays low, and the throughput
// is one beat per clock, set by the single lookup-and-update pass over the
// slot registers.
// Reset is synchronous and restores the register defaults and empties every
// pinned buffer and ring slot. The receiver cannot stall.
module pinned_prefix_round_robin_slot_cache
   import prsc_pkg::*;
#(
   parameter int MAX_LAYERS = MAX_LAYERS_DEF,
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [LAYER_W-1:0]     req_layer,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_evict_valid,
   output logic [LAYER_W-1:0]     rsp_evicted_layer,
   output logic [CNT_W-1:0]       rsp_hit_total,
   output logic [CNT_W-1:0]       rsp_miss_total,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int LIDX_W   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LLIM_W   = $clog2(MAX_LAYERS + 1);
   localparam int LCMP_W   = (LLIM_W > LAYER_CNT_W) ? LLIM_W : LAYER_CNT_W;
   localparam int SIDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SNUM_W   = $clog2(MAX_SLOTS + 1);
   localparam int SCMP_W   = (SNUM_W > SLOT_CNT_W) ? SNUM_W : SLOT_CNT_W;

   // Configuration registers
   logic [LAYER_CNT_W-1:0] layer_count_ff;
   logic [LAYER_CNT_W-1:0] pinned_count_ff;
   logic [SLOT_CNT_W-1:0]  slot_count_ff;
   logic [CSR_DATA_W-1:0]  present_mask_ff;

   // Input register
   logic                   req_valid_ff;
   logic [LAYER_W-1:0]     layer_ff;

   // Cache state
   logic [MAX_LAYERS-1:0]  pinned_loaded_ff;
   logic [MAX_SLOTS-1:0]   occ_valid_ff;
   logic [LAYER_W-1:0]     occ_layer_ff [MAX_SLOTS];
   logic [SIDX_W-1:0]      next_victim_ff, next_victim_in;
   logic [CNT_W-1:0]       hit_count_ff, hit_count_in;
   logic [CNT_W-1:0]       miss_count_ff, miss_count_in;

   // Result register
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_evv_ff, rsp_evv_in;
   logic [LAYER_W-1:0]     rsp_evl_ff, rsp_evl_in;

   // Lookup signals
   logic [LIDX_W-1:0]      lay_idx;
   logic                   in_range;
   logic                   present;
   logic                   is_pinned;
   logic [MAX_SLOTS-1:0]   match_vec;
   logic [SIDX_W-1:0]      hit_slot;
   logic [SNUM_W-1:0]      eff_slots;
   logic [SIDX_W-1:0]      victim;
   logic [SNUM_W-1:0]      victim_plus;
   logic                   do_pin_load;
   logic                   do_ring_load;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff  <= LAYER_COUNT_RST;
         pinned_count_ff <= PINNED_COUNT_RST;
         slot_count_ff   <= SLOT_COUNT_RST;
         present_mask_ff <= PRESENT_MASK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LAYER_COUNT:  layer_count_ff  <= csr_wr_data[LAYER_CNT_W-1:0];
            CSR_PINNED_COUNT: pinned_count_ff <= csr_wr_data[LAYER_CNT_W-1:0];
            CSR_SLOT_COUNT:   slot_count_ff   <= csr_wr_data[SLOT_CNT_W-1:0];
            CSR_PRESENT_MASK: present_mask_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      layer_ff <= req_layer;
   end

   // Lookup: range check, pinned test and an associative search of the ring.
   always_comb begin
      lay_idx   = LIDX_W'(layer_ff);
      in_range  = (LCMP_W'(layer_ff) < LCMP_W'(layer_count_ff)) &&
                  (LCMP_W'(layer_ff) < LCMP_W'(MAX_LAYERS));
      present   = present_mask_ff[layer_ff];
      is_pinned = LAYER_CNT_W'(layer_ff) < pinned_count_ff;

      hit_slot = '0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
         match_vec[s] = occ_valid_ff[s] && (occ_layer_ff[s] == layer_ff);
         hit_slot     = hit_slot | (match_vec[s] ? SIDX_W'(s) : '0);
      end

      if (slot_count_ff == '0) begin
         eff_slots = SNUM_W'(1);
      end else if (SCMP_W'(slot_count_ff) > SCMP_W'(MAX_SLOTS)) begin
         eff_slots = SNUM_W'(MAX_SLOTS);
      end else begin
         eff_slots = SNUM_W'(slot_count_ff);
      end

      // A pointer left beyond a shrunk ring restarts at slot zero.
      victim      = (SNUM_W'(next_victim_ff) < eff_slots) ? next_victim_ff : '0;
      victim_plus = SNUM_W'(victim) + SNUM_W'(1);
   end

   always_comb begin
      rsp_status_in  = ST_ABSENT;
      rsp_slot_in    = '0;
      rsp_evv_in     = 1'b0;
      rsp_evl_in     = '0;
      hit_count_in   = hit_count_ff;
      miss_count_in  = miss_count_ff;
      next_victim_in = next_victim_ff;
      do_pin_load    = 1'b0;
      do_ring_load   = 1'b0;
      priority if (!in_range || !present) begin
         rsp_status_in = ST_ABSENT;
      end else if (is_pinned) begin
         if (pinned_loaded_ff[lay_idx]) begin
            rsp_status_in = ST_PINNED_HIT;
            hit_count_in  = (hit_count_ff == CNT_SAT) ? hit_count_ff
                                                      : hit_count_ff + CNT_W'(1);
         end else begin
            rsp_status_in = ST_PINNED_LOAD;
            do_pin_load   = 1'b1;
            miss_count_in = (miss_count_ff == CNT_SAT) ? miss_count_ff
                                                        : miss_count_ff + CNT_W'(1);
         end
      end else if (|match_vec) begin
         rsp_status_in = ST_RING_HIT;
         rsp_slot_in   = SLOT_W'(hit_slot);
         hit_count_in  = (hit_count_ff == CNT_SAT) ? hit_count_ff
                                                   : hit_count_ff + CNT_W'(1);
      end else begin
         rsp_status_in  = ST_RING_LOAD;
         rsp_slot_in    = SLOT_W'(victim);
         rsp_evv_in     = occ_valid_ff[victim];
         rsp_evl_in     = occ_valid_ff[victim] ? occ_layer_ff[victim] : '0;
         do_ring_load   = 1'b1;
         next_victim_in = (victim_plus >= eff_slots) ? '0 : SIDX_W'(victim_plus);
         miss_count_in  = (miss_count_ff == CNT_SAT) ? miss_count_ff
                                                      : miss_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pinned_loaded_ff <= '0;
         occ_valid_ff     <= '0;
         next_victim_ff   <= '0;
         hit_count_ff     <= '0;
         miss_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            hit_count_ff   <= hit_count_in;
            miss_count_ff  <= miss_count_in;
            next_victim_ff <= next_victim_in;
            if (do_pin_load) begin
               pinned_loaded_ff[lay_idx] <= 1'b1;
            end
            if (do_ring_load) begin
               occ_valid_ff[victim] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && do_ring_load) begin
         occ_layer_ff[victim] <= layer_ff;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_evv_ff    <= rsp_evv_in;
      rsp_evl_ff    <= rsp_evl_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evict_valid   = rsp_evv_ff;
   assign rsp_evicted_layer = rsp_evl_ff;
   assign rsp_hit_total     = hit_count_ff;
   assign rsp_miss_total    = miss_count_ff;

   // Every accepted request gives exactly one result, after the input and result registers.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted request produced no result");

   // A layer lives in at most one ring slot.
   a_unique_slot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("layer found in more than one ring slot");

   // Evictions only come with a ring load.
   a_evict_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evict_valid) |-> (rsp_status == ST_RING_LOAD))
      else $error("eviction reported without a ring load");

   // Counters never move backward.
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hit_count_ff >= $past(hit_count_ff)) &&
               (miss_count_ff >= $past(miss_count_ff)))
      else $error("hit or miss counter decreased");

endmodule
